// ===== rtl/psieve_pkg.sv =====
// ----------------------------------------------------------------------------
// psieve_pkg
// Shared sizes, command codes, sequencer states and unit result type for the
// prime sieve table.
// ----------------------------------------------------------------------------
package psieve_pkg;

	// Table size and derived widths.
	localparam int TABLE_SIZE = 131072;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int NUM_W      = 17;

	// Command codes.
	localparam logic CMD_BUILD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_FILL  = 8'b00000010,
		ST_SQCHK = 8'b00000100,
		ST_CHKI  = 8'b00001000,
		ST_CLR   = 8'b00010000,
		ST_NEXTI = 8'b00100000,
		ST_DONE  = 8'b01000000,
		ST_QRD   = 8'b10000000
	} state_t;

	// Result of the shared add and compare unit.
	typedef struct packed {
		logic [CNT_W-1:0] sum;
		logic             lt;
	} alu_res_t;

endpackage

// ===== rtl/psieve_ram.sv =====
// ----------------------------------------------------------------------------
// psieve_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module psieve_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds between reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/psieve_alu.sv =====
// ----------------------------------------------------------------------------
// psieve_alu
// Shared adder with a bound check against the table size. The sequencer uses
// it for the fill counter, the square of the sieve index and the multiples.
// ----------------------------------------------------------------------------
module psieve_alu (
	input  logic [psieve_pkg::CNT_W-1:0] a,
	input  logic [psieve_pkg::CNT_W-1:0] b,
	output psieve_pkg::alu_res_t         res
);

	// All sums stay below twice the table size, so they fit without wrapping.
	always_comb begin
		res.sum = a + b;
		res.lt  = res.sum < psieve_pkg::CNT_W'(psieve_pkg::TABLE_SIZE);
	end

endmodule

// ===== rtl/prime_sieve_table.sv =====
// ----------------------------------------------------------------------------
// prime_sieve_table
// Primality table of TABLE_SIZE one-bit entries built by the sieve of
// Eratosthenes, with a query port for single entries.
// ----------------------------------------------------------------------------
// A build item fills the table, one entry per cycle, and then sieves: for each
// i with i*i below the size it checks that bound, reads and examines entry i and
// steps to the next i and its square; for every still-marked i it first clears
// the multiples of i, one per cycle. The clearing dominates: it is the sum of
// TABLE_SIZE/p over the primes p below the square root of the size, about twice
// TABLE_SIZE writes, which the one write port of the table RAM takes one at a
// time. A query item issues the read as it is accepted and registers the result
// once the output register is free. The block takes a new item only when its
// sequencer is idle; a finished result may still wait in the output register
// meanwhile. Before the first build, a query returns 0 with table_valid clear,
// and numbers at or beyond the table size read as 0.
module prime_sieve_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic                         command,
	input  logic [psieve_pkg::NUM_W-1:0] number,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic                         is_prime,
	output logic                         table_valid
);

	psieve_pkg::state_t               state_q;
	logic [psieve_pkg::CNT_W-1:0]     cnt_q;
	logic [psieve_pkg::CNT_W-1:0]     i_q;
	logic [psieve_pkg::CNT_W-1:0]     sq_q;
	logic [psieve_pkg::CNT_W-1:0]     j_q;
	logic                             built_q;
	logic                             in_range_q;
	logic                             rsp_valid_q;
	logic                             is_prime_q;
	logic                             table_valid_q;

	logic [psieve_pkg::CNT_W-1:0]     alu_a;
	logic [psieve_pkg::CNT_W-1:0]     alu_b;
	psieve_pkg::alu_res_t             alu_res;

	logic                             wr_en;
	logic [psieve_pkg::CNT_W-1:0]     wr_idx;
	logic                             wr_data;
	logic                             rd_en;
	logic [psieve_pkg::ADDR_W-1:0]    rd_addr;
	logic                             rd_data;

	logic                             cmd_fire;
	logic                             rsp_free;

	assign cmd_ready   = (state_q == psieve_pkg::ST_IDLE);
	assign cmd_fire    = cmd_valid && cmd_ready;
	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign rsp_valid   = rsp_valid_q;
	assign is_prime    = is_prime_q;
	assign table_valid = table_valid_q;

	// Operand selection for the shared unit.
	always_comb begin
		alu_a = cnt_q;
		alu_b = psieve_pkg::CNT_W'(1);
		unique case (state_q)
			psieve_pkg::ST_FILL: begin
				alu_a = cnt_q;
				alu_b = psieve_pkg::CNT_W'(1);
			end
			psieve_pkg::ST_SQCHK: begin
				alu_a = sq_q;
				alu_b = '0;
			end
			psieve_pkg::ST_CHKI: begin
				alu_a = i_q;
				alu_b = i_q;
			end
			psieve_pkg::ST_CLR: begin
				alu_a = j_q;
				alu_b = i_q;
			end
			psieve_pkg::ST_NEXTI: begin
				// (i+1)^2 = i^2 + 2i + 1
				alu_a = sq_q;
				alu_b = psieve_pkg::CNT_W'({i_q, 1'b1});
			end
			default: begin
				alu_a = cnt_q;
				alu_b = psieve_pkg::CNT_W'(1);
			end
		endcase
	end

	psieve_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	// Table RAM access: fill and clear write, query and sieve check read.
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = cnt_q;
		wr_data = 1'b0;
		rd_en   = 1'b0;
		rd_addr = psieve_pkg::ADDR_W'(number);
		unique case (state_q)
			psieve_pkg::ST_IDLE: begin
				rd_en = cmd_fire && (command == psieve_pkg::CMD_QUERY);
			end
			psieve_pkg::ST_FILL: begin
				wr_en   = 1'b1;
				wr_idx  = cnt_q;
				wr_data = cnt_q > psieve_pkg::CNT_W'(1);
			end
			psieve_pkg::ST_SQCHK: begin
				rd_en   = 1'b1;
				rd_addr = psieve_pkg::ADDR_W'(i_q);
			end
			psieve_pkg::ST_CLR: begin
				wr_en  = 1'b1;
				wr_idx = j_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	psieve_ram #(
		.WIDTH (1),
		.DEPTH (psieve_pkg::TABLE_SIZE)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx[psieve_pkg::ADDR_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psieve_pkg::ST_IDLE;
			built_q <= 1'b0;
		end else begin
			unique case (state_q)
				psieve_pkg::ST_IDLE: begin
					if (cmd_fire) begin
						if (command == psieve_pkg::CMD_BUILD) begin
							state_q <= psieve_pkg::ST_FILL;
						end else begin
							state_q <= psieve_pkg::ST_QRD;
						end
					end
				end
				psieve_pkg::ST_FILL: begin
					if (!alu_res.lt) begin
						state_q <= psieve_pkg::ST_SQCHK;
					end
				end
				psieve_pkg::ST_SQCHK: begin
					state_q <= alu_res.lt ? psieve_pkg::ST_CHKI : psieve_pkg::ST_DONE;
				end
				psieve_pkg::ST_CHKI: begin
					state_q <= rd_data ? psieve_pkg::ST_CLR : psieve_pkg::ST_NEXTI;
				end
				psieve_pkg::ST_CLR: begin
					if (!alu_res.lt) begin
						state_q <= psieve_pkg::ST_NEXTI;
					end
				end
				psieve_pkg::ST_NEXTI: begin
					state_q <= psieve_pkg::ST_SQCHK;
				end
				psieve_pkg::ST_DONE: begin
					if (rsp_free) begin
						built_q <= 1'b1;
						state_q <= psieve_pkg::ST_IDLE;
					end
				end
				psieve_pkg::ST_QRD: begin
					if (rsp_free) begin
						state_q <= psieve_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= psieve_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Sieve counters and the query range flag.
	always_ff @(posedge clk) begin
		unique case (state_q)
			psieve_pkg::ST_IDLE: begin
				cnt_q      <= '0;
				in_range_q <= 32'(number) < 32'(psieve_pkg::TABLE_SIZE);
			end
			psieve_pkg::ST_FILL: begin
				cnt_q <= alu_res.sum;
				i_q   <= psieve_pkg::CNT_W'(2);
				sq_q  <= psieve_pkg::CNT_W'(4);
			end
			psieve_pkg::ST_CHKI: begin
				j_q <= alu_res.sum;
			end
			psieve_pkg::ST_CLR: begin
				j_q <= alu_res.sum;
			end
			psieve_pkg::ST_NEXTI: begin
				sq_q <= alu_res.sum;
				i_q  <= i_q + psieve_pkg::CNT_W'(1);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == psieve_pkg::ST_DONE || state_q == psieve_pkg::ST_QRD)
				&& rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload: a build reports a valid table; a query masks the bit.
	always_ff @(posedge clk) begin
		if (state_q == psieve_pkg::ST_DONE && rsp_free) begin
			is_prime_q    <= 1'b0;
			table_valid_q <= 1'b1;
		end else if (state_q == psieve_pkg::ST_QRD && rsp_free) begin
			is_prime_q    <= built_q && in_range_q && rd_data;
			table_valid_q <= built_q;
		end
	end

	// A result with no built table never reports a prime.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !table_valid |-> !is_prime)
		else $error("prime reported before the table was built");

	// Once built, the table stays built.
	assert property (@(posedge clk) disable iff (!arst_n)
		built_q |=> built_q)
		else $error("built flag dropped");

	// Every table write lands inside the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_idx < psieve_pkg::CNT_W'(psieve_pkg::TABLE_SIZE))
		else $error("table write beyond the table size");

	// The sieve only checks indices whose square is below the size.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == psieve_pkg::ST_CHKI |-> $past(alu_res.lt))
		else $error("sieve index checked past its bound");

endmodule

// ===== tb/sv/prime_table_checker.sv =====
// ----------------------------------------------------------------------------
// prime_table_checker
// Watches both channels of the prime sieve table, keeps its own sieve and
// build flag, and compares every returned item with the answer owed for it.
// ----------------------------------------------------------------------------
module prime_table_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  logic                         command,
	input  logic [psieve_pkg::NUM_W-1:0] number,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  logic                         is_prime,
	input  logic                         table_valid,
	output int                           fail_count = 0,
	output int                           pending = 0
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic is_prime;
		logic table_valid;
	} answer_t;

	// Answers owed to the receiver, oldest first.
	answer_t answers_due[$];

	// Private copy of the table contents and the build flag.
	bit prime_bits [psieve_pkg::TABLE_SIZE];
	bit table_built;

	answer_t seen;
	answer_t owed;
	int      factor;
	int      multiple;

	// One line per problem, and the count goes up.
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answers_due.delete();
			table_built = 1'b0;
			pending <= 0;
		end else begin
			// Returned items first: none can belong to a command taken at this edge.
			if (rsp_valid && rsp_ready) begin
				seen = '{is_prime: is_prime, table_valid: table_valid};
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("result item with nothing owed (is_prime=%b table_valid=%b)",
						is_prime, table_valid));
				end else begin
					owed = answers_due.pop_front();
					if (seen.is_prime !== owed.is_prime)
						report_mismatch($sformatf("is_prime expected %b got %b",
							owed.is_prime, seen.is_prime));
					if (seen.table_valid !== owed.table_valid)
						report_mismatch($sformatf("table_valid expected %b got %b",
							owed.table_valid, seen.table_valid));
				end
			end

			// A build reruns the whole sieve; a query reads the private table.
			if (cmd_valid && cmd_ready) begin
				if (command == psieve_pkg::CMD_BUILD) begin
					for (multiple = 0; multiple < psieve_pkg::TABLE_SIZE; multiple++)
						prime_bits[multiple] = 1'b1;
					prime_bits[0] = 1'b0;
					prime_bits[1] = 1'b0;
					for (factor = 2; factor * factor < psieve_pkg::TABLE_SIZE;
							factor++) begin
						if (prime_bits[factor]) begin
							for (multiple = factor + factor;
									multiple < psieve_pkg::TABLE_SIZE;
									multiple += factor)
								prime_bits[multiple] = 1'b0;
						end
					end
					table_built = 1'b1;
					owed = '{is_prime: 1'b0, table_valid: 1'b1};
				end else begin
					owed.is_prime    = (table_built && number < psieve_pkg::TABLE_SIZE) ?
						prime_bits[number] : 1'b0;
					owed.table_valid = table_built;
				end
				answers_due = {answers_due, owed};
			end

			pending <= answers_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the prime sieve table: queries before any build,
// a build, directed probes at the edges of the table, then random queries
// with one more build mixed in, under bursty sending and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// No item is accepted while a build runs.
	localparam int WATCHDOG_LIMIT = 2_000_000;
	localparam int RANDOM_ITEMS   = 1030;
	localparam int DRAIN_CYCLES   = 16;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cmd_valid   = 1'b0;
	logic                         cmd_ready;
	logic                         command     = psieve_pkg::CMD_QUERY;
	logic [psieve_pkg::NUM_W-1:0] number      = '0;
	logic                         rsp_valid;
	logic                         rsp_ready   = 1'b0;
	logic                         is_prime;
	logic                         table_valid;

	int fail_count;
	int pending;

	// Probes taken before the first build: all zeros, all ones, alternating bits.
	int unsigned early_probes [4] = '{0, 131071, 43690, 87381};

	// Probes after the build: tiny numbers, squares near the sieve limit,
	// powers of two and the top of the range.
	int unsigned edge_probes [16] = '{0, 1, 2, 3, 4, 9, 25, 97, 359, 361, 65536,
		65537, 128881, 130321, 131070, 131071};

	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;
	int idle_cycles = 0;

	always #1 clk = ~clk;

	prime_sieve_table u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.number      (number),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.is_prime    (is_prime),
		.table_valid (table_valid)
	);

	prime_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.number      (number),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.is_prime    (is_prime),
		.table_valid (table_valid),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Sends one item; opens a new burst, after a random gap, when the last one ran out.
	task automatic send_command(input logic cmd, input int unsigned num);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		burst_left--;
		cmd_valid <= 1'b1;
		command   <= cmd;
		number    <= num[psieve_pkg::NUM_W-1:0];
		do @(posedge clk); while (!cmd_ready);
	endtask

	// Receiver: steady, coin-flip, mostly stalled, or stretches that end fully stalled.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(3);
			stall_left = $urandom_range(4, 60);
		end
		stall_left--;
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(1));
			2: rsp_ready <= ($urandom_range(7) == 0);
			default: rsp_ready <= (stall_left > 30);
		endcase
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int          build_at;
		int          idx;
		int unsigned pick;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries before any build must come back as zero with the flag clear.
		foreach (early_probes[k])
			send_command(psieve_pkg::CMD_QUERY, early_probes[k]);

		// First build, with a number that the block should ignore.
		send_command(psieve_pkg::CMD_BUILD, 131071);
		foreach (edge_probes[k])
			send_command(psieve_pkg::CMD_QUERY, edge_probes[k]);

		// Random queries over small, top-end and uniform numbers, with one rebuild.
		build_at = $urandom_range(100, 900);
		for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
			if (idx == build_at) begin
				send_command(psieve_pkg::CMD_BUILD, $urandom_range(131071));
			end else begin
				case ($urandom_range(3))
					0: pick = $urandom_range(1023);
					1: pick = $urandom_range(130048, 131071);
					default: pick = $urandom_range(131071);
				endcase
				send_command(psieve_pkg::CMD_QUERY, pick);
			end
		end
		cmd_valid <= 1'b0;

		// The owed count of the last accepted item is registered, so wait for it to show.
		@(posedge clk);

		// Let every owed answer arrive, then wait DRAIN_CYCLES for stray items.
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/psieve_pkg.sv
rtl/psieve_ram.sv
rtl/psieve_alu.sv
rtl/prime_sieve_table.sv
tb/sv/prime_table_checker.sv
tb/sv/testbench.sv
